[src/ready_queue_sorted_insert_macros.svh]
// assertion helpers for the ready queue
`ifndef READY_QUEUE_SORTED_INSERT_MACROS_SVH
`define READY_QUEUE_SORTED_INSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RQSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ready queue check failed");
// next-cycle implication
`define RQSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ready queue check failed");
`else
`define RQSI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RQSI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/rqsi_pkg.sv]
package rqsi_pkg;

	localparam int CAPACITY_DEF = 16;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// ordering policies
	localparam logic [1:0] POL_SJF  = 2'd0;
	localparam logic [1:0] POL_PRIO = 2'd1;
	localparam logic [1:0] POL_FIFO = 2'd2;
	localparam logic [1:0] POL_BAD  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_BAD_POLICY = 3'd4;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} rec_t;

	typedef struct packed {
		logic [2:0] status;
		rec_t       rec;
		logic [4:0] occupancy;
	} res_t;

	typedef struct packed {
		logic busy;
		logic over_cap;
	} mon_t;

	// sort key of a record under a policy
	function automatic logic [15:0] key_of(rec_t r, logic [1:0] pol);
		logic [15:0] k;
		k = (pol == POL_SJF) ? r.burst : {8'd0, r.prio};
		return k;
	endfunction

endpackage

[src/rqsi_if.sv]
interface rqsi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] proc_id;
	logic [15:0] arrival;
	logic [15:0] burst;
	logic [7:0]  prio;

	modport source (output valid, operation, proc_id, arrival, burst, prio, input ready);
	modport sink (input valid, operation, proc_id, arrival, burst, prio, output ready);
endinterface

interface rqsi_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] out_id;
	logic [15:0] out_arrival;
	logic [15:0] out_burst;
	logic [7:0]  out_prio;
	logic [4:0]  occupancy;

	modport source (output valid, status, out_id, out_arrival, out_burst, out_prio, occupancy,
		input ready);
	modport sink (input valid, status, out_id, out_arrival, out_burst, out_prio, occupancy,
		output ready);
endinterface

[src/rqsi_mem.sv]
module rqsi_mem import rqsi_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(CAPACITY_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/rqsi_cmp.sv]
module rqsi_cmp import rqsi_pkg::*; (
	input  logic [1:0] pol,
	input  rec_t       lhs,
	input  rec_t       rhs,
	output logic       key_ge,
	output logic       id_eq
);

	logic [15:0] key_l;
	logic [15:0] key_r;

	// key select and compare
	always_comb begin
		key_l  = key_of(lhs, pol);
		key_r  = key_of(rhs, pol);
		key_ge = (key_l >= key_r);
		id_eq  = (lhs.id == rhs.id);
	end

endmodule

[src/rqsi_ctrl.sv]
module rqsi_ctrl import rqsi_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IW       = $clog2(CAPACITY_DEF),
	parameter int CW       = $clog2(CAPACITY_DEF + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    policy,
	rqsi_in_if.sink       in_ch,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res,
	output mon_t          mon,
	output logic          mem_we,
	output logic [IW-1:0] mem_waddr,
	output rec_t          mem_wdata,
	output logic [IW-1:0] mem_raddr,
	input  rec_t          mem_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	rec_t          rec_q;
	rec_t          carry_q;
	logic          found_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [2:0]    status_q;
	rec_t          got_q;

	logic          accept;
	logic          rd_more;
	logic          walk_end;
	logic          key_ge;
	logic          id_eq;
	logic          place;
	logic          del_hit;
	rec_t          in_rec;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_rec      = '{id: in_ch.proc_id, arrival: in_ch.arrival, burst: in_ch.burst,
		prio: in_ch.prio};

	// shared compare unit: stored entry against the held record
	rqsi_cmp u_cmp (
		.pol    (policy),
		.lhs    (mem_rdata),
		.rhs    (rec_q),
		.key_ge (key_ge),
		.id_eq  (id_eq)
	);

	// walk control
	assign rd_more   = (state_q == S_WALK) && (rd_q < cnt_q);
	assign walk_end  = (state_q == S_WALK) && !rd_more && !vld_s1;
	assign place     = found_q || ((policy != POL_FIFO) && key_ge);
	assign del_hit   = (op_q == OP_POP) || id_eq;
	assign mem_raddr = rd_q[IW-1:0];

	// memory write: ripple the carried entry forward, or close the gap
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if ((state_q == S_WALK) && vld_s1) begin
			if (op_q == OP_INSERT) begin
				if (place) begin
					mem_we    = 1'b1;
					mem_wdata = found_q ? carry_q : rec_q;
				end
			end else if (found_q) begin
				mem_we    = 1'b1;
				mem_waddr = idx_s1 - IW'(1);
			end
		end else if (walk_end && (op_q == OP_INSERT)) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[IW-1:0];
			mem_wdata = found_q ? carry_q : rec_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			op_q    <= OP_INSERT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= in_ch.operation;
						found_q <= 1'b0;
						rd_q    <= '0;
						vld_s1  <= 1'b0;
						unique case (in_ch.operation)
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_FIN;
							end
							OP_INSERT: begin
								if ((policy == POL_BAD) || (cnt_q >= CW'(CAPACITY))) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_WALK;
								end
							end
							OP_POP: begin
								state_q <= (cnt_q == '0) ? S_FIN : S_WALK;
							end
							OP_DELETE: begin
								state_q <= S_WALK;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_WALK: begin
					vld_s1 <= rd_more;
					if (rd_more) begin
						rd_q <= rd_q + CW'(1);
					end
					if (vld_s1) begin
						if (op_q == OP_INSERT) begin
							if (place) begin
								found_q <= 1'b1;
							end
						end else if (!found_q && del_hit) begin
							found_q <= 1'b1;
						end
					end
					if (walk_end) begin
						if (op_q == OP_INSERT) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (found_q) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: held record, carried entry, result status
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IW-1:0];
		if (accept) begin
			rec_q <= in_rec;
			got_q <= '0;
			priority if (in_ch.operation == OP_CLEAR) begin
				status_q <= ST_OK;
			end else if (in_ch.operation == OP_INSERT && policy == POL_BAD) begin
				status_q <= ST_BAD_POLICY;
			end else if (in_ch.operation == OP_INSERT && cnt_q >= CW'(CAPACITY)) begin
				status_q <= ST_FULL;
			end else if (in_ch.operation == OP_POP && cnt_q == '0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
		if ((state_q == S_WALK) && vld_s1) begin
			if (op_q == OP_INSERT) begin
				if (place) begin
					carry_q <= mem_rdata;
				end
			end else if (!found_q && del_hit && (op_q == OP_POP)) begin
				got_q <= mem_rdata;
			end
		end
		if (walk_end && (op_q != OP_INSERT) && !found_q) begin
			status_q <= ST_NOT_FOUND;
		end
	end

	// result toward the output register
	assign res_valid = (state_q == S_FIN);
	assign res       = '{status: status_q, rec: got_q, occupancy: 5'(cnt_q)};

	assign mon.busy     = (state_q != S_IDLE);
	assign mon.over_cap = (cnt_q > CW'(CAPACITY));

endmodule

[src/ready_queue_sorted_insert.sv]
// Ready queue of process records kept in key order (insertion order under the FIFO policy),
// one operation per input transaction and one result transaction for each. Insert, pop, and
// delete walk the stored entries through a memory with one write port and one registered read
// port, one entry per cycle with a shared key/id comparator; clear, a rejected insert and a pop
// on an empty queue skip the walk. The block takes one operation at a time; a finished result
// waits in the output register while the next operation is accepted. The policy register may
// be written only while the queue is idle. No clearing pass is needed after reset.
`include "ready_queue_sorted_insert_macros.svh"

module ready_queue_sorted_insert import rqsi_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	rqsi_in_if.sink     in_ch,
	rqsi_out_if.source  out_ch
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [1:0]    policy_q;
	logic          out_vld_q;
	res_t          out_res_q;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	mon_t          mon;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	rec_t          mem_wdata;
	logic [IW-1:0] mem_raddr;
	rec_t          mem_rdata;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_SJF;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	rqsi_mem #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rqsi_ctrl #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mon       (mon),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.status      = out_res_q.status;
	assign out_ch.out_id      = out_res_q.rec.id;
	assign out_ch.out_arrival = out_res_q.rec.arrival;
	assign out_ch.out_burst   = out_res_q.rec.burst;
	assign out_ch.out_prio    = out_res_q.rec.prio;
	assign out_ch.occupancy   = out_res_q.occupancy;

	// entry count stays within capacity
	`RQSI_ASSERT_IMP(a_count_in_range, clk, arst_n, 1'b1, !mon.over_cap)
	// a result with a non-OK status carries an all-zero record
	`RQSI_ASSERT_IMP(a_record_zero, clk, arst_n, out_ch.valid && (out_ch.status != ST_OK), (out_ch.out_id == 16'd0) && (out_ch.out_arrival == 16'd0) && (out_ch.out_burst == 16'd0) && (out_ch.out_prio == 8'd0))
	// one operation at a time
	`RQSI_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready && mon.busy)

endmodule
